[hdl/tba_pkg.sv]
// Shared types, constants and corner selection table for the transformed box AABB block.
// No dependencies.
package tba_pkg;
	localparam int CORNER_COUNT = 8;
	localparam int CIDX_W = $clog2(CORNER_COUNT);
	localparam int DIV_STEPS = 48;

	localparam logic [2:0] REG_MIN_X = 3'd0;
	localparam logic [2:0] REG_MIN_Y = 3'd1;
	localparam logic [2:0] REG_MIN_Z = 3'd2;
	localparam logic [2:0] REG_MAX_X = 3'd3;
	localparam logic [2:0] REG_MAX_Y = 3'd4;
	localparam logic [2:0] REG_MAX_Z = 3'd5;

	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_SUM, ST_DIV, ST_EMIT, ST_BOX
	} state_t;

	// bit0: x uses max, bit1: y uses max, bit2: z uses max
	function automatic logic [2:0] corner_sel(input logic [CIDX_W-1:0] k);
		logic [2:0] s;
		case (k)
			3'd0: s = 3'd0;
			3'd1: s = 3'd2;
			3'd2: s = 3'd3;
			3'd3: s = 3'd1;
			3'd4: s = 3'd4;
			3'd5: s = 3'd6;
			3'd6: s = 3'd7;
			3'd7: s = 3'd5;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
		if (v > 52'sd2147483647) return S32_MAX;
		if (v < -52'sd2147483648) return S32_MIN;
		return v[31:0];
	endfunction

	function automatic logic ovf32(input logic signed [51:0] v);
		return (v > 52'sd2147483647) || (v < -52'sd2147483648);
	endfunction
endpackage

[hdl/tba_lane.sv]
// One coordinate lane: restoring divider computing (n*65536)/w with saturation.
// Depends on tba_pkg.
module tba_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [31:0]  n,
	input  logic signed [31:0]  w,
	output logic                done,
	output logic signed [31:0]  res,
	output logic                flt
);
	import tba_pkg::*;

	logic [47:0] num_q;
	logic [31:0] den_q;
	logic [32:0] rem_q;
	logic [47:0] quo_q;
	logic        neg_q, wz_q, nsgn_q, nz_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;
	logic [32:0] sub;
	logic signed [49:0] sq;

	assign trial = {rem_q[31:0], num_q[47]};
	assign sub = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'(DIV_STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == 6'd0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {(n[31] ? 32'(-n) : n), 16'd0};
			den_q <= w[31] ? 32'(-w) : w;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= n[31] ^ w[31];
			wz_q <= (w == 32'sd0);
			nsgn_q <= n[31];
			nz_q <= (n == 32'sd0);
		end else if (busy_q && cnt_q != 6'd0) begin
			num_q <= {num_q[46:0], 1'b0};
			if (!sub[32]) begin
				rem_q <= sub;
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	// last cycle: one more step is folded into the final result
	logic [47:0] qf;
	assign qf = {quo_q[46:0], ~sub[32]};
	assign sq = neg_q ? -$signed({2'b0, qf}) : $signed({2'b0, qf});
	assign done = busy_q && cnt_q == 6'd0;

	always_comb begin
		if (wz_q) begin
			flt = 1'b1;
			res = nz_q ? 32'sd0 : (nsgn_q ? S32_MIN : S32_MAX);
		end else begin
			flt = (sq > 50'sd2147483647) || (sq < -50'sd2147483648);
			res = (sq > 50'sd2147483647) ? S32_MAX :
			      (sq < -50'sd2147483648) ? S32_MIN : sq[31:0];
		end
	end
endmodule

[hdl/tba_merge.sv]
// Merging stage: running AABB minimum, maximum and fault accumulation over corners.
// Depends on tba_pkg.
module tba_merge (
	input  logic               clk,
	input  logic               clear,
	input  logic               load,
	input  logic signed [31:0] cx,
	input  logic signed [31:0] cy,
	input  logic signed [31:0] cz,
	input  logic               cflt,
	output logic signed [31:0] mn_x, mn_y, mn_z,
	output logic signed [31:0] mx_x, mx_y, mx_z,
	output logic               any_flt
);
	import tba_pkg::*;
	logic first_q;
	always_ff @(posedge clk) begin
		if (clear) begin
			first_q <= 1'b1;
			any_flt <= 1'b0;
		end else if (load) begin
			first_q <= 1'b0;
			any_flt <= any_flt | cflt;
			if (first_q || cx < mn_x) mn_x <= cx;
			if (first_q || cy < mn_y) mn_y <= cy;
			if (first_q || cz < mn_z) mn_z <= cz;
			if (first_q || cx > mx_x) mx_x <= cx;
			if (first_q || cy > mx_y) mx_y <= cy;
			if (first_q || cz > mx_z) mx_z <= cz;
		end
	end
endmodule

[hdl/transformed_box_aabb.sv]
// Transformed box AABB top level. Rows 0-2 are only stored, no result.
// Row 3 starts a run: per corner a multiply state and a sum state, then the divider
// in three parallel lanes (x, y, z), then one output transfer; nine results per run.
// Input is stalled during a run.
// Reset (arst_n low) clears the matrix, the box registers, the state, the corner counter and the lane counters.
module transformed_box_aabb (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  row_index,
	input  logic signed [31:0]          elem_0, elem_1, elem_2, elem_3,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [2:0]                  cfg_index,
	input  logic [31:0]                 cfg_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        is_box,
	output logic [tba_pkg::CIDX_W-1:0]  corner_index,
	output logic signed [31:0]          x, y, z, hi_x, hi_y, hi_z,
	output logic                        fault,
	output logic                        last
);
	import tba_pkg::*;

	state_t state_q, state_d;
	logic signed [31:0] m_q [16];
	logic signed [31:0] lmin_q [3];
	logic signed [31:0] lmax_q [3];
	logic [CIDX_W-1:0] k_q;
	logic signed [63:0] prod_s1 [12];
	logic sflt_q;
	logic lane_done [3];
	logic signed [31:0] lres [3];
	logic lflt [3];
	logic signed [31:0] mn_x, mn_y, mn_z, mx_x, mx_y, mx_z;
	logic any_flt;
	logic accept, fire;

	assign cfg_ready = 1'b1;
	assign accept = in_valid && !in_stall;
	assign fire = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) m_q[i] <= '0;
			for (int i = 0; i < 3; i++) begin
				lmin_q[i] <= '0;
				lmax_q[i] <= '0;
			end
		end else begin
			if (accept) begin
				m_q[{row_index, 2'd0}] <= elem_0;
				m_q[{row_index, 2'd1}] <= elem_1;
				m_q[{row_index, 2'd2}] <= elem_2;
				m_q[{row_index, 2'd3}] <= elem_3;
			end
			if (cfg_valid) begin
				case (cfg_index)
					REG_MIN_X: lmin_q[0] <= cfg_data;
					REG_MIN_Y: lmin_q[1] <= cfg_data;
					REG_MIN_Z: lmin_q[2] <= cfg_data;
					REG_MAX_X: lmax_q[0] <= cfg_data;
					REG_MAX_Y: lmax_q[1] <= cfg_data;
					REG_MAX_Z: lmax_q[2] <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) k_q <= '0;
			else if (state_q == ST_EMIT && fire) k_q <= k_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && row_index == 2'd3) state_d = ST_MUL;
			ST_MUL:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_DIV;
			ST_DIV:  if (lane_done[0]) state_d = ST_EMIT;
			ST_EMIT: if (fire) state_d = (k_q == CIDX_W'(CORNER_COUNT - 1)) ? ST_BOX : ST_MUL;
			ST_BOX:  if (fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// twelve 32x32 products, one per matrix element of rows 0-2
	logic [2:0] sel;
	assign sel = corner_sel(k_q);
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 4; c++)
					prod_s1[r*4+c] <= (sel[r] ? lmax_q[r] : lmin_q[r]) * m_q[r*4+c];
		end
	end

	logic signed [51:0] csum [4];
	always_comb begin
		for (int c = 0; c < 4; c++)
			csum[c] = 52'(m_q[12+c]) + 52'(prod_s1[c] >>> 16) + 52'(prod_s1[4+c] >>> 16)
			          + 52'(prod_s1[8+c] >>> 16);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SUM)
			sflt_q <= ovf32(csum[0]) | ovf32(csum[1]) | ovf32(csum[2]) | ovf32(csum[3]);
	end

	function automatic logic signed [31:0] csum_sel(input int j);
		return sat32(csum[j]);
	endfunction

	logic res_ok_q;
	logic signed [31:0] r_q [3];
	logic rflt_q;
	for (genvar j = 0; j < 3; j++) begin : g_lane
		tba_lane u_lane (
			.clk(clk), .arst_n(arst_n), .start(state_q == ST_SUM && state_d == ST_DIV),
			.n(csum_sel(j)), .w(sat32(csum[3])), .done(lane_done[j]),
			.res(lres[j]), .flt(lflt[j])
		);
	end

	always_ff @(posedge clk) begin
		if (lane_done[0]) begin
			for (int j = 0; j < 3; j++) r_q[j] <= lres[j];
			rflt_q <= sflt_q | lflt[0] | lflt[1] | lflt[2];
		end
	end
	assign res_ok_q = 1'b1;

	tba_merge u_merge (
		.clk(clk), .clear(accept), .load(state_q == ST_EMIT && fire && res_ok_q),
		.cx(r_q[0]), .cy(r_q[1]), .cz(r_q[2]), .cflt(rflt_q),
		.mn_x(mn_x), .mn_y(mn_y), .mn_z(mn_z), .mx_x(mx_x), .mx_y(mx_y), .mx_z(mx_z),
		.any_flt(any_flt)
	);

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_EMIT) || (state_q == ST_BOX);
		is_box = (state_q == ST_BOX);
		last = is_box;
		corner_index = is_box ? '0 : k_q;
		x = is_box ? mn_x : r_q[0];
		y = is_box ? mn_y : r_q[1];
		z = is_box ? mn_z : r_q[2];
		hi_x = is_box ? mx_x : 32'sd0;
		hi_y = is_box ? mx_y : 32'sd0;
		hi_z = is_box ? mx_z : 32'sd0;
		fault = is_box ? any_flt : rflt_q;
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !accept) else $error("input taken during run");
	a_lanes_together: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done[0] |-> (lane_done[1] && lane_done[2])) else $error("lanes out of step");
	// the corner counter wraps to zero on the last corner transfer
	a_box_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BOX) |-> (k_q == '0)) else $error("box early");
endmodule

[test/tb.sv]
// Self-checking testbench for transformed_box_aabb: loads matrix rows, predicts the
// eight world corners and the bounding box of each run, and checks every output transfer.
// Depends on tba_pkg and transformed_box_aabb.
module tb;
	import tba_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic        is_box;
		logic [2:0]  corner_index;
		logic [31:0] x, y, z, hi_x, hi_y, hi_z;
		logic        fault;
		logic        last;
	} aabb_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] row_index = '0;
	logic signed [31:0] elem_0 = '0, elem_1 = '0, elem_2 = '0, elem_3 = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic is_box;
	logic [CIDX_W-1:0] corner_index;
	logic signed [31:0] x, y, z, hi_x, hi_y, hi_z;
	logic fault, last;

	transformed_box_aabb u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic signed [31:0] matrix_copy [16];
	logic signed [31:0] box_lo [3];
	logic signed [31:0] box_hi [3];
	aabb_item_t expected_items [$];

	int mismatches = 0;
	int unexpected = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int idle_cycles = 0;

	function automatic logic signed [63:0] clamp32(input logic signed [63:0] v, inout logic f);
		if (v > 64'sd2147483647) begin
			f = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			f = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// transform one corner, returning world coords and fault
	task automatic transform_corner(input logic [2:0] sel, output logic signed [31:0] res [3],
			output logic f);
		logic signed [63:0] p [3];
		logic signed [63:0] n [4];
		logic signed [63:0] s, q;
		f = 1'b0;
		for (int j = 0; j < 3; j++)
			p[j] = sel[j] ? 64'(box_hi[j]) : 64'(box_lo[j]);
		for (int c = 0; c < 4; c++) begin
			s = 64'(matrix_copy[12 + c]);
			for (int r = 0; r < 3; r++)
				s += (p[r] * 64'(matrix_copy[r * 4 + c])) >>> 16;
			n[c] = clamp32(s, f);
		end
		for (int j = 0; j < 3; j++) begin
			if (n[3] == 0) begin
				f = 1'b1;
				q = (n[j] > 0) ? 64'sd2147483647 : (n[j] < 0) ? -64'sd2147483648 : 64'sd0;
			end else begin
				q = clamp32((n[j] * 64'sd65536) / n[3], f);
			end
			res[j] = q[31:0];
		end
	endtask

	task automatic predict_row(input logic [1:0] r, input logic signed [31:0] e [4]);
		aabb_item_t it;
		logic signed [31:0] res [3];
		logic signed [31:0] mn [3];
		logic signed [31:0] mx [3];
		logic f, any_f;
		for (int c = 0; c < 4; c++) matrix_copy[r * 4 + c] = e[c];
		if (r != 2'd3) return;
		any_f = 1'b0;
		for (int k = 0; k < CORNER_COUNT; k++) begin
			transform_corner(corner_sel(k[2:0]), res, f);
			for (int j = 0; j < 3; j++) begin
				if (k == 0 || res[j] < mn[j]) mn[j] = res[j];
				if (k == 0 || res[j] > mx[j]) mx[j] = res[j];
			end
			any_f |= f;
			it = '{1'b0, k[2:0], res[0], res[1], res[2], 32'd0, 32'd0, 32'd0, f, 1'b0};
			expected_items.push_back(it);
		end
		it = '{1'b1, 3'd0, mn[0], mn[1], mn[2], mx[0], mx[1], mx[2], any_f, 1'b1};
		expected_items.push_back(it);
	endtask

	// valid stays high after the transfer so a following row can go back to back;
	// an idle cycle or drain() drops it
	task automatic send_row(input logic [1:0] r, input logic signed [31:0] e [4]);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		row_index <= r;
		elem_0 <= e[0];
		elem_1 <= e[1];
		elem_2 <= e[2];
		elem_3 <= e[3];
		predict_row(r, e);
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx <= REG_MAX_Z) begin
			if (idx < REG_MAX_X) box_lo[idx[1:0]] = v;
			else box_hi[2'(idx - REG_MAX_X)] = v;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_items.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_q16();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			3: return $urandom_range(0, 8) << 16;
			default: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	task automatic set_box(input logic [31:0] a, b, c, d, e, f);
		write_reg(REG_MIN_X, a);
		write_reg(REG_MIN_Y, b);
		write_reg(REG_MIN_Z, c);
		write_reg(REG_MAX_X, d);
		write_reg(REG_MAX_Y, e);
		write_reg(REG_MAX_Z, f);
	endtask

	task automatic load_matrix(input logic signed [31:0] m [16]);
		logic signed [31:0] e [4];
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) e[c] = m[r * 4 + c];
			send_row(r[1:0], e);
		end
	endtask

	task automatic test_identity();
		logic signed [31:0] m [16];
		for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'sh10000 : 32'sh0;
		set_box(32'hffff0000, 32'hfffe0000, 32'hfffd0000, 32'h10000, 32'h20000, 32'h30000);
		load_matrix(m);
		// min above max, scale and translate
		drain();
		set_box(32'h50000, 32'h40000, 32'h0, 32'hfffb0000, 32'h8000, 32'h1);
		m[0] = 32'sh20000; m[12] = 32'sh70000; m[15] = 32'sh20000;
		load_matrix(m);
	endtask

	task automatic test_zero_w();
		logic signed [31:0] e [4];
		e = '{32'sh10000, 32'shffff0000, 32'sh0, 32'sh0};
		send_row(2'd3, e);
		e = '{32'sh0, 32'sh0, 32'sh0, 32'sh0};
		send_row(2'd3, e);
	endtask

	task automatic test_extremes();
		logic signed [31:0] m [16];
		drain();
		set_box(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		for (int i = 0; i < 16; i++) m[i] = (i % 2) ? 32'sh7fffffff : 32'sh80000000;
		load_matrix(m);
		for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'sh1 : 32'shffffffff;
		load_matrix(m);
		// unknown register indexes are dropped
		drain();
		write_reg(3'd6, 32'hdeadbeef);
		write_reg(3'd7, 32'h12345678);
	endtask

	task automatic test_random(input int items);
		logic signed [31:0] e [4];
		int r;
		r = 0;
		for (int i = 0; i < items; i++) begin
			for (int c = 0; c < 4; c++) e[c] = rand_q16();
			// mostly in-order row loads, some stray rows
			if ($urandom_range(9) < 8) begin
				send_row(r[1:0], e);
				r = (r + 1) % 4;
			end else begin
				send_row(2'($urandom_range(3)), e);
			end
			if (i % 40 == 39) begin
				drain();
				set_box(rand_q16(), rand_q16(), rand_q16(),
					rand_q16(), rand_q16(), rand_q16());
			end
		end
	endtask

	// stall the output at the phase rate
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		aabb_item_t got, want;
		if (out_valid && !out_stall) begin
			got = '{is_box, corner_index, x, y, z, hi_x, hi_y, hi_z, fault, last};
			if (expected_items.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= 10)
					$display("unexpected transfer: %p", got);
			end else begin
				want = expected_items.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches + unexpected <= 10)
						$display("mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("transformed_box_aabb verification failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < 16; i++) matrix_copy[i] = '0;
		for (int j = 0; j < 3; j++) begin
			box_lo[j] = '0;
			box_hi[j] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_identity();
		test_zero_w();
		test_extremes();
		test_random(95);
		send_idle_pct = 63;
		test_random(95);
		send_idle_pct = 0;
		stall_pct = 63;
		test_random(95);
		send_idle_pct = 36;
		stall_pct = 36;
		test_random(95);
		drain();
		if (mismatches == 0 && unexpected == 0 && expected_items.size() == 0)
			$display("transformed_box_aabb verification clean");
		else
			$display("transformed_box_aabb verification failed");
		$finish;
	end
endmodule

[transformed_box_aabb.f]
hdl/tba_pkg.sv
hdl/tba_lane.sv
hdl/tba_merge.sv
hdl/transformed_box_aabb.sv
test/tb.sv
